FILE: design/ccb_pkg.sv
// Shared types, constants and control structs of the lower CSC builder.
`default_nettype none
package ccb_pkg;

	localparam int MAX_ORDER   = 1024;
	localparam int MAX_ENTRIES = 4096;
	localparam int PTR_DEPTH   = MAX_ORDER + 1;
	localparam int EA_W        = $clog2(MAX_ENTRIES);
	localparam int PA_W        = $clog2(PTR_DEPTH);

	typedef enum logic [2:0] {
		REQ_CLEAR    = 3'd0,
		REQ_LOAD     = 3'd1,
		REQ_BUILD    = 3'd2,
		REQ_READ_PTR = 3'd3,
		REQ_READ_ENT = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DROPPED = 2'd1,
		ST_FULL    = 2'd2,
		ST_BAD_IDX = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_LD_RD, S_LD_CMP, S_RD_WAIT,
		S_BD_RD, S_BD_CHK, S_BD_PFILL, S_BD_TAIL, S_DONE
	} state_t;

	typedef struct packed {
		logic [9:0]         row;
		logic [9:0]         col;
		logic signed [31:0] value;
	} entry_t;

	typedef struct packed {
		logic    capture;
		logic    clear;
		logic    set_code;
		status_t code;
		logic    ld_init;
		logic    ld_rd;
		logic    ld_shift;
		logic    ld_put;
		logic    rd_issue;
		logic    bd_init;
		logic    bd_rd;
		logic    bd_skip;
		logic    bd_merge;
		logic    bd_new;
		logic    bd_pfill;
		logic    bd_flush;
		logic    bd_finish;
		logic    result_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req;
		status_t    ld_code;
		logic       rd_ok;
		logic       j_zero;
		logic       ld_gt;
		logic       bd_more;
		logic       bd_drop;
		logic       bd_dup;
		logic       pfill_more;
		logic       tail_more;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

FILE: design/ccb_ctrl.sv
// Controller state machine of the lower CSC builder.
`default_nettype none
module ccb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire ccb_pkg::stat_t st,
	output ccb_pkg::cmd_t       cmd
);

	ccb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ccb_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.code = ccb_pkg::ST_OK;
		case (state_q)
			ccb_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ccb_pkg::S_EXEC;
				end
			end
			ccb_pkg::S_EXEC: begin
				cmd.set_code = 1'b1;
				case (st.req)
					ccb_pkg::REQ_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = ccb_pkg::S_DONE;
					end
					ccb_pkg::REQ_LOAD: begin
						cmd.code = st.ld_code;
						if (st.ld_code == ccb_pkg::ST_OK) begin
							cmd.ld_init = 1'b1;
							state_d     = ccb_pkg::S_LD_RD;
						end else begin
							state_d = ccb_pkg::S_DONE;
						end
					end
					ccb_pkg::REQ_BUILD: begin
						cmd.bd_init = 1'b1;
						state_d     = ccb_pkg::S_BD_RD;
					end
					ccb_pkg::REQ_READ_PTR, ccb_pkg::REQ_READ_ENT: begin
						if (st.rd_ok) begin
							cmd.rd_issue = 1'b1;
							state_d      = ccb_pkg::S_RD_WAIT;
						end else begin
							cmd.code = ccb_pkg::ST_BAD_IDX;
							state_d  = ccb_pkg::S_DONE;
						end
					end
					default: begin
						cmd.code = ccb_pkg::ST_BAD_IDX;
						state_d  = ccb_pkg::S_DONE;
					end
				endcase
			end
			ccb_pkg::S_LD_RD: begin
				if (st.j_zero) begin
					cmd.ld_put = 1'b1;
					state_d    = ccb_pkg::S_DONE;
				end else begin
					cmd.ld_rd = 1'b1;
					state_d   = ccb_pkg::S_LD_CMP;
				end
			end
			ccb_pkg::S_LD_CMP: begin
				if (st.ld_gt) begin
					cmd.ld_shift = 1'b1;
					state_d      = ccb_pkg::S_LD_RD;
				end else begin
					cmd.ld_put = 1'b1;
					state_d    = ccb_pkg::S_DONE;
				end
			end
			ccb_pkg::S_RD_WAIT: begin
				state_d = ccb_pkg::S_DONE;
			end
			ccb_pkg::S_BD_RD: begin
				if (st.bd_more) begin
					cmd.bd_rd = 1'b1;
					state_d   = ccb_pkg::S_BD_CHK;
				end else begin
					cmd.bd_flush = 1'b1;
					state_d      = ccb_pkg::S_BD_TAIL;
				end
			end
			ccb_pkg::S_BD_CHK: begin
				if (st.bd_drop) begin
					cmd.bd_skip = 1'b1;
					state_d     = ccb_pkg::S_BD_RD;
				end else if (st.bd_dup) begin
					cmd.bd_merge = 1'b1;
					state_d      = ccb_pkg::S_BD_RD;
				end else begin
					cmd.bd_new = 1'b1;
					state_d    = ccb_pkg::S_BD_PFILL;
				end
			end
			ccb_pkg::S_BD_PFILL: begin
				if (st.pfill_more) begin
					cmd.bd_pfill = 1'b1;
				end else begin
					state_d = ccb_pkg::S_BD_RD;
				end
			end
			ccb_pkg::S_BD_TAIL: begin
				if (st.tail_more) begin
					cmd.bd_pfill = 1'b1;
				end else begin
					cmd.bd_finish = 1'b1;
					state_d       = ccb_pkg::S_DONE;
				end
			end
			ccb_pkg::S_DONE: begin
				if (st.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ccb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ccb_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/ccb_dpath.sv
// Datapath of the lower CSC builder: entry and pointer memories, counters, result word.
`default_nettype none
module ccb_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [10:0]        cfg_data,
	input  wire logic [2:0]         req_type,
	input  wire logic [15:0]        row_in,
	input  wire logic [15:0]        col_in,
	input  wire logic signed [31:0] value_in,
	input  wire logic [12:0]        index_in,
	input  wire ccb_pkg::cmd_t      cmd,
	output ccb_pkg::stat_t          st,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [12:0]             count,
	output logic [12:0]             pointer_out,
	output logic [9:0]              row_out,
	output logic signed [31:0]      value_out
);

	ccb_pkg::entry_t entry_mem [ccb_pkg::MAX_ENTRIES];
	logic [12:0]     ptr_mem   [ccb_pkg::PTR_DEPTH];

	logic [10:0]        order_q;
	logic               sym_q;
	logic [2:0]         req_q;
	logic [15:0]        row1_q, col1_q;
	logic signed [31:0] val_q;
	logic [12:0]        idx_q;
	logic [12:0]        count_q;
	logic               built_q;
	logic [10:0]        border_q;
	logic [12:0]        j_q, i_q, m_q;
	logic [10:0]        pnext_q;
	ccb_pkg::entry_t    acc_q;
	logic               acc_v_q;
	ccb_pkg::status_t   code_q;
	ccb_pkg::entry_t    erd_q;
	logic [12:0]        prd_q;

	logic [10:0]        eff_o;
	logic               bad_coord;
	logic [9:0]         r0, c0;
	ccb_pkg::entry_t    new_ent;
	logic [12:0]        jm1;
	logic signed [32:0] sum;
	logic signed [31:0] sat;

	// Clamp the order register to 1..MAX_ORDER.
	always_comb begin
		if (order_q == 11'd0) begin
			eff_o = 11'd1;
		end else if (order_q > 11'(ccb_pkg::MAX_ORDER)) begin
			eff_o = 11'(ccb_pkg::MAX_ORDER);
		end else begin
			eff_o = order_q;
		end
	end

	assign bad_coord = (row1_q == 16'd0) || (col1_q == 16'd0) ||
		(row1_q > {5'd0, eff_o}) || (col1_q > {5'd0, eff_o});
	assign r0 = row1_q[9:0] - 10'd1;
	assign c0 = col1_q[9:0] - 10'd1;

	always_comb begin
		new_ent.value = val_q;
		if (r0 < c0) begin
			new_ent.row = c0;
			new_ent.col = r0;
		end else begin
			new_ent.row = r0;
			new_ent.col = c0;
		end
	end

	assign jm1 = j_q - 13'd1;

	// Saturating Q16.16 sum of the accumulator and the word just read.
	assign sum = {acc_q.value[31], acc_q.value} + {erd_q.value[31], erd_q.value};
	always_comb begin
		if (sum[32] != sum[31]) begin
			sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat = sum[31:0];
		end
	end

	always_comb begin
		st.req = req_q;
		if (bad_coord || ((r0 < c0) && !sym_q)) begin
			st.ld_code = ccb_pkg::ST_DROPPED;
		end else if (count_q == 13'(ccb_pkg::MAX_ENTRIES)) begin
			st.ld_code = ccb_pkg::ST_FULL;
		end else begin
			st.ld_code = ccb_pkg::ST_OK;
		end
		if (req_q == ccb_pkg::REQ_READ_PTR) begin
			st.rd_ok = built_q && (idx_q <= {2'd0, border_q});
		end else begin
			st.rd_ok = built_q && (idx_q < count_q);
		end
		st.j_zero     = (j_q == 13'd0);
		st.ld_gt      = {erd_q.col, erd_q.row} > {new_ent.col, new_ent.row};
		st.bd_more    = (i_q < count_q);
		st.bd_drop    = ({1'b0, erd_q.row} >= eff_o);
		st.bd_dup     = acc_v_q && (erd_q.col == acc_q.col) && (erd_q.row == acc_q.row);
		st.pfill_more = (pnext_q <= {1'b0, acc_q.col});
		st.tail_more  = (pnext_q <= eff_o);
		st.out_free   = !out_valid || !out_stall;
	end

	// Entry memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (cmd.ld_shift) begin
			entry_mem[j_q[ccb_pkg::EA_W-1:0]] <= erd_q;
		end else if (cmd.ld_put) begin
			entry_mem[j_q[ccb_pkg::EA_W-1:0]] <= new_ent;
		end else if ((cmd.bd_new || cmd.bd_flush) && acc_v_q) begin
			entry_mem[m_q[ccb_pkg::EA_W-1:0]] <= acc_q;
		end
		if (cmd.ld_rd) begin
			erd_q <= entry_mem[jm1[ccb_pkg::EA_W-1:0]];
		end else if (cmd.rd_issue) begin
			erd_q <= entry_mem[idx_q[ccb_pkg::EA_W-1:0]];
		end else if (cmd.bd_rd) begin
			erd_q <= entry_mem[i_q[ccb_pkg::EA_W-1:0]];
		end
	end

	// Pointer memory.
	always_ff @(posedge clk) begin
		if (cmd.bd_pfill) begin
			ptr_mem[pnext_q[ccb_pkg::PA_W-1:0]] <= m_q;
		end
		if (cmd.rd_issue) begin
			prd_q <= ptr_mem[idx_q[ccb_pkg::PA_W-1:0]];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			row1_q <= row_in;
			col1_q <= col_in;
			val_q  <= value_in;
			idx_q  <= index_in;
		end
		if (cmd.set_code) begin
			code_q <= cmd.code;
		end
		if (cmd.ld_init) begin
			j_q <= count_q;
		end else if (cmd.ld_shift) begin
			j_q <= jm1;
		end
		if (cmd.bd_new) begin
			acc_q <= erd_q;
		end else if (cmd.bd_merge) begin
			acc_q.value <= sat;
		end
		if (cmd.result_load) begin
			status      <= code_q;
			count       <= count_q;
			pointer_out <= 13'd0;
			row_out     <= 10'd0;
			value_out   <= 32'sd0;
			if (code_q == ccb_pkg::ST_OK && req_q == ccb_pkg::REQ_READ_PTR) begin
				pointer_out <= prd_q;
			end
			if (code_q == ccb_pkg::ST_OK && req_q == ccb_pkg::REQ_READ_ENT) begin
				row_out   <= erd_q.row;
				value_out <= erd_q.value;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q   <= 11'd1;
			sym_q     <= 1'b0;
			count_q   <= 13'd0;
			built_q   <= 1'b0;
			border_q  <= 11'd1;
			i_q       <= 13'd0;
			m_q       <= 13'd0;
			pnext_q   <= 11'd0;
			acc_v_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'b0) begin
					order_q <= cfg_data;
				end else begin
					sym_q <= cfg_data[0];
				end
			end
			if (cmd.clear) begin
				count_q <= 13'd0;
				built_q <= 1'b0;
			end else if (cmd.ld_put) begin
				count_q <= count_q + 13'd1;
				built_q <= 1'b0;
			end else if (cmd.bd_finish) begin
				count_q  <= m_q;
				built_q  <= 1'b1;
				border_q <= eff_o;
			end
			if (cmd.bd_init) begin
				i_q     <= 13'd0;
				m_q     <= 13'd0;
				pnext_q <= 11'd0;
				acc_v_q <= 1'b0;
			end else begin
				if (cmd.bd_skip || cmd.bd_merge || cmd.bd_new) begin
					i_q <= i_q + 13'd1;
				end
				if ((cmd.bd_new || cmd.bd_flush) && acc_v_q) begin
					m_q <= m_q + 13'd1;
				end
				if (cmd.bd_new) begin
					acc_v_q <= 1'b1;
				end else if (cmd.bd_flush) begin
					acc_v_q <= 1'b0;
				end
				if (cmd.bd_pfill) begin
					pnext_q <= pnext_q + 11'd1;
				end
			end
			if (cmd.result_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/coo_to_lower_csc_builder.sv
// Top level of the COO to lower CSC builder.
`default_nettype none
// Takes one request word at a time: clear, load one 1-based (row, column, value)
// triple, build, read a column pointer or read a merged entry. Each request
// returns exactly one result word, held in an output register until taken.
// Loads keep the store sorted by column then row as they arrive: a load walks
// from the end of the store toward its slot, shifting each stored entry that
// sorts after the new one up by one place. A build walks the sorted store once,
// dropping rows beyond the current order and summing duplicates with saturation,
// and fills order+1 column pointers. A new result word waits while the previous
// one is stalled. The entry memory holds 4096 words of row, column and value.
// The memories need no clearing after reset; the input stalls while a request
// is in work.
module coo_to_lower_csc_builder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [10:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         req_type,
	input  wire logic [15:0]        row_in,
	input  wire logic [15:0]        col_in,
	input  wire logic signed [31:0] value_in,
	input  wire logic [12:0]        index_in,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [12:0]             count,
	output logic [12:0]             pointer_out,
	output logic [9:0]              row_out,
	output logic signed [31:0]      value_out
);

	ccb_pkg::cmd_t  cmd;
	ccb_pkg::stat_t st;

	// Sequence each request.
	ccb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Hold the store, pointers and the result word.
	ccb_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_type    (req_type),
		.row_in      (row_in),
		.col_in      (col_in),
		.value_in    (value_in),
		.index_in    (index_in),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.count       (count),
		.pointer_out (pointer_out),
		.row_out     (row_out),
		.value_out   (value_out)
	);

endmodule
`default_nettype wire

FILE: design/ccb_checker.sv
// Port-level checks of the lower CSC builder and their binding.
`default_nettype none
module ccb_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [1:0]         status,
	input wire logic [12:0]        count,
	input wire logic [12:0]        pointer_out,
	input wire logic [9:0]         row_out,
	input wire logic signed [31:0] value_out
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_hold_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(count))
		else $error("stalled result word changed");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ccb_pkg::ST_OK |->
		pointer_out == 13'd0 && row_out == 10'd0 && value_out == 32'sd0)
		else $error("failed request returned data");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ccb_pkg::ST_FULL |->
		count == 13'(ccb_pkg::MAX_ENTRIES))
		else $error("store full reported below capacity");

endmodule

bind coo_to_lower_csc_builder ccb_checker u_ccb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.count       (count),
	.pointer_out (pointer_out),
	.row_out     (row_out),
	.value_out   (value_out)
);
`default_nettype wire
